[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, skipped while aresetn is low.
`define SWHC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("swhc assertion failed");

// Checked on every rising edge of aclk, also during reset.
`define SWHC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("swhc assertion failed");

`endif

[src/swhc_pkg.sv]
// Types and constants shared by the sliding window hit counter modules.
package swhc_pkg;

    localparam int TS_W      = 32;
    localparam int WIN_W     = 10;
    localparam int CNT_W     = 16;
    localparam int HIT_W     = 25;
    localparam int TDATA_W   = 32;
    localparam int BUCKETS_DEFAULT = 512;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 16'hFFFF;

    // Input kinds carried on s_tuser
    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One bucket of the ring
    typedef struct packed {
        logic             valid;
        logic [TS_W-1:0]  second;
        logic [CNT_W-1:0] count;
    } bucket_t;

    // Control from the sequencer to the window accumulator
    typedef struct packed {
        logic clear;
        logic en;
    } acc_ctl_t;

endpackage

[src/sliding_window_hit_counter.sv]
// Top level of the sliding window hit counter: sequencer, register and output stage.
//
// Usage:
//   s_tuser selects the kind of item: 0 records a hit at s_tdata (seconds),
//   1 asks how many hits lie in (timestamp - window, timestamp]. Timestamps
//   must not decrease. Only a query yields a transfer on the m_ channel.
//   cfg_wr_en / cfg_wr_data set the window length; write only while idle.
//   BUCKETS must be a power of two: the slot is the low timestamp bits.
// Timing:
//   A hit takes the slot in ST_DIV, then reads (ST_HIT_RD) and writes
//   (ST_HIT_WR) the bucket memory.
//   A query walks the bucket memory once, one bucket a cycle, through the
//   shared window adder, then passes ST_DRAIN and ST_OUT, where its result
//   is loaded into the output register. s_tready is low meanwhile.
// Reset:
//   aresetn (synchronous, active low) loads the window with 300 and runs a
//   clearing pass over every bucket of the memory with s_tready low.
// Stalls:
//   A result is held in an output register until m_tready; new items are
//   accepted meanwhile, and a finished query waits for the register to free.
module sliding_window_hit_counter #(
    parameter int BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [swhc_pkg::WIN_W-1:0]    cfg_wr_data,   // window_seconds
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swhc_pkg::TDATA_W-1:0]  s_tdata,       // [31:0] timestamp
    input  logic                          s_tuser,       // [0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swhc_pkg::TDATA_W-1:0]  m_tdata        // [24:0] hit_count, [31:25] zero
);
    import swhc_pkg::*;

    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int SPAN_W = $clog2(BUCKETS+1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_HIT_RD, ST_HIT_WR, ST_SCAN, ST_DRAIN, ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  window_reg;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [HIT_W-1:0]  m_data_reg, m_data_next;

    logic              s_xfer;
    logic              div_start, div_done;
    logic [IDX_W-1:0]  slot;
    logic              ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
    bucket_t           ram_wr_data, ram_rd_data;
    acc_ctl_t          acc_ctl;
    logic [HIT_W-1:0]  acc_count;
    logic              same_second;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // Window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    swhc_slot_div #(.BUCKETS(BUCKETS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ts_reg[IDX_W-1:0]),
        .done     (div_done),
        .slot     (slot)
    );

    swhc_bucket_ram #(.BUCKETS(BUCKETS)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swhc_window_acc #(.BUCKETS(BUCKETS)) u_acc (
        .aclk      (aclk),
        .ctl       (acc_ctl),
        .entry     (ram_rd_data),
        .ts        (ts_reg),
        .span      (span_reg),
        .hit_count (acc_count)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        ts_next       = ts_reg;
        span_next     = span_reg;
        idx_next      = idx_reg;
        rd_vld_next   = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = slot;
        ram_wr_data   = '0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = slot;
        acc_ctl.clear = 1'b0;
        acc_ctl.en    = rd_vld_reg;
        same_second   = ram_rd_data.valid && (ram_rd_data.second == ts_reg);

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    ts_next  = s_tdata[TS_W-1:0];
                    idx_next = '0;
                    if (s_tuser == CMD_QUERY) begin
                        acc_ctl.clear = 1'b1;
                        span_next  = (32'(window_reg) > 32'(BUCKETS)) ? SPAN_W'(BUCKETS)
                                                                      : SPAN_W'(window_reg);
                        state_next = ST_SCAN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_HIT_RD;
                end
            end
            ST_HIT_RD: begin
                ram_rd_en  = 1'b1;
                state_next = ST_HIT_WR;
            end
            ST_HIT_WR: begin
                // Same second: count up to saturation; otherwise take the bucket over
                ram_wr_en          = 1'b1;
                ram_wr_data.valid  = 1'b1;
                ram_wr_data.second = ts_reg;
                if (same_second) begin
                    ram_wr_data.count = (ram_rd_data.count == COUNT_MAX)
                                        ? COUNT_MAX : ram_rd_data.count + 1'b1;
                end else begin
                    ram_wr_data.count = CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg;
                rd_vld_next = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(BUCKETS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = acc_count;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ts_reg     <= ts_next;
        span_reg   <= span_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_W - HIT_W)'(0), m_data_reg};

endmodule

[src/swhc_bucket_ram.sv]
// Bucket ring storage: one write port, one registered read port.
module swhc_bucket_ram #(
    parameter int BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(BUCKETS)-1:0]  wr_addr,
    input  swhc_pkg::bucket_t           wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(BUCKETS)-1:0]  rd_addr,
    output swhc_pkg::bucket_t           rd_data
);
    import swhc_pkg::*;

    bucket_t mem [BUCKETS];
    bucket_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/swhc_slot_div.sv]
// Bucket slot of a timestamp: the low timestamp bits; done rises in the cycle after start.
module swhc_slot_div #(
    parameter int BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [$clog2(BUCKETS)-1:0]  dividend,
    output logic                        done,
    output logic [$clog2(BUCKETS)-1:0]  slot
);

    logic done_reg, done_next;

    // Ring size is a power of two, so the slot is a mask of the timestamp
    always_comb begin
        done_next = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign slot = dividend;

endmodule

[src/swhc_window_acc.sv]
// Shared window test and saturating adder, one bucket per cycle.
module swhc_window_acc #(
    parameter int BUCKETS = swhc_pkg::BUCKETS_DEFAULT
) (
    input  logic                           aclk,
    input  swhc_pkg::acc_ctl_t             ctl,
    input  swhc_pkg::bucket_t              entry,
    input  logic [swhc_pkg::TS_W-1:0]      ts,
    input  logic [$clog2(BUCKETS+1)-1:0]   span,
    output logic [swhc_pkg::HIT_W-1:0]     hit_count
);
    import swhc_pkg::*;

    logic [HIT_W-1:0] acc_reg, acc_next;
    logic [TS_W:0]    age;
    logic             in_window;
    logic [HIT_W:0]   sum;

    // Age of the bucket; the borrow bit marks a second after the query
    always_comb begin
        age       = {1'b0, ts} - {1'b0, entry.second};
        in_window = entry.valid && !age[TS_W] && (age[TS_W-1:0] < TS_W'(span));
        sum       = {1'b0, acc_reg} + (HIT_W+1)'(entry.count);
        acc_next  = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.en && in_window) begin
            acc_next = sum[HIT_W] ? '1 : sum[HIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign hit_count = acc_reg;

endmodule

[src/swhc_checker.sv]
// Port-level checks for the sliding window hit counter, bound to the top level.
`include "assert_macros.svh"

module swhc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [swhc_pkg::TDATA_W-1:0]  m_tdata
);
    import swhc_pkg::*;

    // A stalled result holds
    `SWHC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Padding above the count stays zero
    `SWHC_ASSERT(a_out_pad, m_tvalid |-> m_tdata[TDATA_W-1:HIT_W] == '0)
    // Busy right after any accepted item
    `SWHC_ASSERT(a_busy_after_xfer, s_tvalid && s_tready |=> !s_tready)
    // A hit never raises a result in the next cycle
    `SWHC_ASSERT(a_hit_silent, s_tvalid && s_tready && s_tuser == CMD_HIT |=> !$rose(m_tvalid))
    // Clearing pass after reset keeps the input closed
    `SWHC_ASSERT_ALWAYS(a_reset_closed, !aresetn |=> !s_tready && !m_tvalid)

endmodule

bind sliding_window_hit_counter swhc_checker u_swhc_checker (.*);

[tb/testbench.sv]
// Self-checking bench for the sliding window hit counter: directed script, then random phases.
module testbench;
    import swhc_pkg::*;

    localparam int BUCKETS       = BUCKETS_DEFAULT;
    localparam int SETTLE_CYCLES = BUCKETS + 64;   // longest item plus margin
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam logic [HIT_W-1:0] HIT_COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ROW_HIT,
        ROW_QUERY,
        ROW_WINDOW
    } row_kind_e;

    // One line of the directed script; hit_count is used only when pinned is set
    typedef struct packed {
        row_kind_e        kind;
        logic [TS_W-1:0]  value;
        logic             pinned;
        logic [HIT_W-1:0] hit_count;
    } script_row_t;

    localparam int SCRIPT_ROWS = 22;

    script_row_t script [SCRIPT_ROWS] = '{
        '{ROW_QUERY,  32'd0,          1'b1, 25'd0},  // empty ring after reset
        '{ROW_HIT,    32'd0,          1'b0, 25'd0},
        '{ROW_HIT,    32'd0,          1'b0, 25'd0},
        '{ROW_QUERY,  32'd0,          1'b1, 25'd2},
        '{ROW_QUERY,  32'd299,        1'b1, 25'd2},  // oldest second still inside
        '{ROW_QUERY,  32'd300,        1'b1, 25'd0},  // just fell out
        '{ROW_HIT,    32'd511,        1'b0, 25'd0},
        '{ROW_HIT,    32'd512,        1'b0, 25'd0},  // takes over bucket 0
        '{ROW_QUERY,  32'd512,        1'b1, 25'd2},
        '{ROW_WINDOW, 32'd0,          1'b0, 25'd0},  // zero window
        '{ROW_QUERY,  32'd512,        1'b1, 25'd0},
        '{ROW_WINDOW, 32'd1023,       1'b0, 25'd0},  // clamped to the ring size
        '{ROW_QUERY,  32'd1022,       1'b1, 25'd2},
        '{ROW_WINDOW, 32'd1,          1'b0, 25'd0},
        '{ROW_QUERY,  32'd512,        1'b1, 25'd1},
        '{ROW_HIT,    32'hFFFF_FFFF,  1'b0, 25'd0},
        '{ROW_QUERY,  32'hFFFF_FFFF,  1'b1, 25'd1},
        '{ROW_HIT,    32'd511,        1'b0, 25'd0},  // earlier second reclaims bucket
        '{ROW_QUERY,  32'hFFFF_FFFF,  1'b1, 25'd0},
        '{ROW_WINDOW, 32'd512,        1'b0, 25'd0},
        '{ROW_QUERY,  32'd100,        1'b1, 25'd0},  // query before every stored second
        '{ROW_QUERY,  32'd1023,       1'b1, 25'd1}
    };

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic               s_tuser     = CMD_HIT;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // Predictor state: mirror of the bucket ring and the window register
    logic [TS_W-1:0]  ring_second [BUCKETS];
    logic             ring_live   [BUCKETS];
    logic [CNT_W-1:0] ring_hits   [BUCKETS];
    logic [WIN_W-1:0] window_len;

    logic [HIT_W-1:0] expected_hit_counts [$];
    logic [HIT_W-1:0] oldest_count;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    logic             steady         = 1'b0;  // suppresses idling on both sides

    always #2 aclk = ~aclk;

    sliding_window_hit_counter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Idle with a chance of 8 in 100, never while steady
    function automatic logic take_break();
        return !steady && ($urandom_range(99) < 8);
    endfunction

    // Append one predicted result at the tail of the scoreboard queue
    function automatic void queue_expected(input logic [HIT_W-1:0] count);
        expected_hit_counts.insert(expected_hit_counts.size(), count);
    endfunction

    // Saturating sum of bucket counts whose second lies in (ts - window, ts], window capped at BUCKETS
    function automatic logic [HIT_W-1:0] count_in_window(input logic [TS_W-1:0] ts);
        longint unsigned total;
        int unsigned     span;
        total = 0;
        span  = (window_len > BUCKETS) ? BUCKETS : window_len;
        for (int i = 0; i < BUCKETS; i++) begin
            if (ring_live[i] && ring_second[i] <= ts && ts - ring_second[i] < span)
                total += ring_hits[i];
        end
        if (total > HIT_COUNT_MAX)
            total = HIT_COUNT_MAX;
        return total[HIT_W-1:0];
    endfunction

    // Bump the bucket of this second, or take it over with a count of one
    function automatic void record_hit(input logic [TS_W-1:0] ts);
        int unsigned slot;
        slot = ts % BUCKETS;
        if (ring_live[slot] && ring_second[slot] == ts) begin
            if (ring_hits[slot] != COUNT_MAX)
                ring_hits[slot] += 1'b1;
        end else begin
            ring_second[slot] = ts;
            ring_live[slot]   = 1'b1;
            ring_hits[slot]   = CNT_W'(1);
        end
    endfunction

    // Drive one item until its transfer, then predict; maybe leave a gap
    task automatic push_item(input logic cmd, input logic [TS_W-1:0] ts,
                             input logic pinned, input logic [HIT_W-1:0] pinned_count);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ts;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_HIT)
            record_hit(ts);
        else
            queue_expected(pinned ? pinned_count : count_in_window(ts));
        if (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (take_break()) @(posedge aclk);
        end
    endtask

    // Stop sending, drain results, then let a trailing hit finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_hit_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        window_len = w;
    endtask

    // Result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hit_counts.size() == 0) begin
                $error("hit_count expected none got %0d", m_tdata[HIT_W-1:0]);
                mismatch_count++;
            end else begin
                oldest_count = expected_hit_counts.pop_front();
                if (m_tdata[HIT_W-1:0] !== oldest_count) begin
                    $error("hit_count expected %0d got %0d", oldest_count, m_tdata[HIT_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[TDATA_W-1:HIT_W] !== '0) begin
                    $error("m_tdata pad expected 0 got %0h", m_tdata[TDATA_W-1:HIT_W]);
                    mismatch_count++;
                end
            end
        end
        m_tready <= !take_break();
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [TS_W-1:0]  clock_now;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  step;
        logic [WIN_W-1:0] w;
        logic             cmd;
        int               pick;

        foreach (ring_live[i]) begin
            ring_live[i]   = 1'b0;
            ring_second[i] = '0;
            ring_hits[i]   = '0;
        end
        window_len = WINDOW_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script
        foreach (script[r]) begin
            case (script[r].kind)
                ROW_WINDOW: set_window(script[r].value[WIN_W-1:0]);
                ROW_HIT:    push_item(CMD_HIT, script[r].value, 1'b0, '0);
                default:    push_item(CMD_QUERY, script[r].value, script[r].pinned,
                                      script[r].hit_count);
            endcase
        end

        // Random phases: mostly rising time with bursts in one second, some stray items
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       w = 10'd1;
                1:       w = 10'd512;
                2:       w = '0;
                3:       w = '1;
                4:       w = WIN_W'($urandom_range(511, 2));
                default: w = WIN_W'($urandom_range(1023, 0));
            endcase
            set_window(w);
            steady    = (p == 1);
            clock_now = $urandom;
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    // stray item anywhere in time, possibly going backward
                    ts  = $urandom;
                    cmd = 1'($urandom_range(1, 0));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        step = 0;
                    else if (pick < 85)
                        step = $urandom_range(3, 1);
                    else if (pick < 95)
                        step = $urandom_range(40, 4);
                    else
                        step = $urandom_range(1200, 200);
                    clock_now += step;
                    ts  = clock_now;
                    cmd = ($urandom_range(99) < 30) ? CMD_QUERY : CMD_HIT;
                end
                push_item(cmd, ts, 1'b0, '0);
            end
        end
        steady = 1'b0;

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
